FILE: design/rtca_pkg.sv
// ----------------------------------------------------------------------------
// rtca_pkg
// Shared widths, codes and types for the retransmit tracker.
// ----------------------------------------------------------------------------
package rtca_pkg;

   localparam int DEPTH_DEFAULT = 16;

   localparam int ACTION_W = 2;
   localparam int ID_W     = 32;
   localparam int TIME_W   = 32;
   localparam int KIND_W   = 3;
   localparam int RTT_W    = 24;

   // timeout = floor(12 * rtt / 5); 12 * rtt fits in 28 bits
   localparam int SCALED_W    = RTT_W + 4;
   localparam int RECIP_W     = 32;
   localparam logic [RECIP_W-1:0] RECIP = 32'hCCCC_CCCD;
   localparam int RECIP_SHIFT = 34;
   localparam int PROD_W      = SCALED_W + RECIP_W;
   localparam int TIMEOUT_W   = PROD_W - RECIP_SHIFT;

   localparam logic [ACTION_W-1:0] ACT_SEND    = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_CONFIRM = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_TICK    = 2'd2;

   localparam logic [KIND_W-1:0] KIND_TRANSMIT   = 3'd0;
   localparam logic [KIND_W-1:0] KIND_RELEASE    = 3'd1;
   localparam logic [KIND_W-1:0] KIND_RETRANSMIT = 3'd2;
   localparam logic [KIND_W-1:0] KIND_UNTRACKED  = 3'd3;
   localparam logic [KIND_W-1:0] KIND_DONE       = 3'd4;

   typedef struct packed {
      logic              valid;
      logic [KIND_W-1:0] kind;
      logic [ID_W-1:0]   id;
      logic              last;
   } emit_type;

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_SCAN = 3'b010,
      ST_DONE = 3'b100
   } state_type;

endpackage

FILE: design/rtca_if.sv
// ----------------------------------------------------------------------------
// rtca_if
// Request and response channel interfaces, valid/ready handshake.
// ----------------------------------------------------------------------------
interface rtca_req_if import rtca_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [ACTION_W-1:0] action;
   logic [ID_W-1:0]     pack_id;
   logic [TIME_W-1:0]   now;

   modport source (output valid, action, pack_id, now, input ready);
   modport sink   (input valid, action, pack_id, now, output ready);
endinterface

interface rtca_rsp_if import rtca_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [KIND_W-1:0] kind;
   logic [ID_W-1:0]   out_id;
   logic              last;

   modport source (output valid, kind, out_id, last, input ready);
   modport sink   (input valid, kind, out_id, last, output ready);
endinterface

FILE: design/rtca_ram.sv
// ----------------------------------------------------------------------------
// rtca_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module rtca_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16,
   localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      // read data holds while rd_en is low
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: design/rtca_timeout.sv
// ----------------------------------------------------------------------------
// rtca_timeout
// Round-trip register and retransmit timeout, floor(12 * rtt / 5).
// ----------------------------------------------------------------------------
module rtca_timeout import rtca_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 wr_en,
   input  logic [RTT_W-1:0]     wr_data,
   output logic [TIMEOUT_W-1:0] timeout
);

   logic [RTT_W-1:0]     rtt_ff, rtt_in;
   logic [TIMEOUT_W-1:0] timeout_ff, timeout_in;
   logic [SCALED_W-1:0]  scaled;
   logic [PROD_W-1:0]    prod;

   assign rtt_in = wr_en ? wr_data : rtt_ff;

   // 12*x = 8*x + 4*x, then divide by 5 through the reciprocal
   assign scaled = {1'b0, rtt_ff, 3'b000} + {2'b00, rtt_ff, 2'b00};
   assign prod   = PROD_W'(scaled) * PROD_W'(RECIP);
   assign timeout_in = prod[PROD_W-1:RECIP_SHIFT];

   always_ff @(posedge clock) begin
      if (reset) begin
         rtt_ff     <= '0;
         timeout_ff <= '0;
      end else begin
         rtt_ff     <= rtt_in;
         timeout_ff <= timeout_in;
      end
   end

   assign timeout = timeout_ff;

endmodule

FILE: design/rtca_engine.sv
// ----------------------------------------------------------------------------
// rtca_engine
// Table control: appends on send, scans the id/time RAMs on confirm and tick
// with a one-entry read-ahead, compacts on confirm, restamps on tick.
// ----------------------------------------------------------------------------
module rtca_engine import rtca_pkg::*; #(
   parameter int TABLE_DEPTH = DEPTH_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   rtca_req_if.sink             req_bus,
   input  logic [TIMEOUT_W-1:0] timeout,
   input  logic                 out_free,
   output emit_type             emit
);

   localparam int CW = $clog2(TABLE_DEPTH + 1);
   localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

   state_type           state_ff, state_in;
   logic [CW-1:0]       count_ff, count_in;
   logic [CW-1:0]       rd_idx_ff, rd_idx_in;
   logic [CW-1:0]       keep_ff, keep_in;
   logic [AW-1:0]       pidx_ff, pidx_in;
   logic                pv_ff, pv_in;
   logic [ACTION_W-1:0] act_ff, act_in;
   logic [ID_W-1:0]     id_ff, id_in;
   logic [TIME_W-1:0]   now_ff, now_in;

   logic              id_we, time_we, rd_en, issue;
   logic [AW-1:0]     id_waddr, time_waddr;
   logic [ID_W-1:0]   id_wdata, id_rd;
   logic [TIME_W-1:0] time_wdata, time_rd, age;

   assign req_bus.ready = (state_ff == ST_IDLE) && out_free;
   assign age = now_ff - time_rd;

   always_comb begin
      state_in   = state_ff;
      count_in   = count_ff;
      rd_idx_in  = rd_idx_ff;
      keep_in    = keep_ff;
      pidx_in    = pidx_ff;
      pv_in      = pv_ff;
      act_in     = act_ff;
      id_in      = id_ff;
      now_in     = now_ff;
      id_we      = 1'b0;
      time_we    = 1'b0;
      id_waddr   = keep_ff[AW-1:0];
      time_waddr = keep_ff[AW-1:0];
      id_wdata   = id_rd;
      time_wdata = time_rd;
      rd_en      = 1'b0;
      issue      = 1'b0;
      emit       = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_bus.valid && req_bus.ready) begin
               act_in    = req_bus.action;
               id_in     = req_bus.pack_id;
               now_in    = req_bus.now;
               rd_idx_in = '0;
               keep_in   = '0;
               pv_in     = 1'b0;
               state_in  = ST_DONE;
               unique case (req_bus.action) inside
                  ACT_SEND: begin
                     emit.valid = 1'b1;
                     emit.id    = req_bus.pack_id;
                     if (count_ff < CW'(TABLE_DEPTH)) begin
                        id_we      = 1'b1;
                        time_we    = 1'b1;
                        id_waddr   = count_ff[AW-1:0];
                        time_waddr = count_ff[AW-1:0];
                        id_wdata   = req_bus.pack_id;
                        time_wdata = req_bus.now;
                        count_in   = count_ff + 1'b1;
                        emit.kind  = KIND_TRANSMIT;
                     end else begin
                        emit.kind  = KIND_UNTRACKED;
                     end
                  end
                  ACT_CONFIRM, ACT_TICK: begin
                     if (count_ff != '0) begin
                        state_in = ST_SCAN;
                     end
                  end
                  default: ;
               endcase
            end
         end
         ST_SCAN: begin
            // whole scan stalls while the response slot is occupied
            if (out_free) begin
               issue     = (rd_idx_ff != count_ff);
               rd_en     = issue;
               pv_in     = issue;
               pidx_in   = rd_idx_ff[AW-1:0];
               if (issue) begin
                  rd_idx_in = rd_idx_ff + 1'b1;
               end
               if (pv_ff) begin
                  if (act_ff == ACT_CONFIRM) begin
                     if (id_ff >= id_rd) begin
                        emit.valid = 1'b1;
                        emit.kind  = KIND_RELEASE;
                        emit.id    = id_rd;
                     end else begin
                        // survivor moves down to the compaction slot
                        id_we   = 1'b1;
                        time_we = 1'b1;
                        keep_in = keep_ff + 1'b1;
                     end
                  end else begin
                     if (age >= TIME_W'(timeout)) begin
                        emit.valid = 1'b1;
                        emit.kind  = KIND_RETRANSMIT;
                        emit.id    = id_rd;
                        time_we    = 1'b1;
                        time_waddr = pidx_ff;
                        time_wdata = now_ff;
                     end
                  end
                  if (!issue) begin
                     state_in = ST_DONE;
                     if (act_ff == ACT_CONFIRM) begin
                        count_in = keep_in;
                     end
                  end
               end
            end
         end
         ST_DONE: begin
            if (out_free) begin
               emit.valid = 1'b1;
               emit.kind  = KIND_DONE;
               emit.id    = '0;
               emit.last  = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         count_ff  <= '0;
         rd_idx_ff <= '0;
         keep_ff   <= '0;
         pv_ff     <= 1'b0;
      end else begin
         state_ff  <= state_in;
         count_ff  <= count_in;
         rd_idx_ff <= rd_idx_in;
         keep_ff   <= keep_in;
         pv_ff     <= pv_in;
      end
   end

   always_ff @(posedge clock) begin
      pidx_ff <= pidx_in;
      act_ff  <= act_in;
      id_ff   <= id_in;
      now_ff  <= now_in;
   end

   rtca_ram #(
      .WIDTH (ID_W),
      .DEPTH (TABLE_DEPTH)
   ) u_id_ram (
      .clock   (clock),
      .wr_en   (id_we),
      .wr_addr (id_waddr),
      .wr_data (id_wdata),
      .rd_en   (rd_en),
      .rd_addr (rd_idx_ff[AW-1:0]),
      .rd_data (id_rd)
   );

   rtca_ram #(
      .WIDTH (TIME_W),
      .DEPTH (TABLE_DEPTH)
   ) u_time_ram (
      .clock   (clock),
      .wr_en   (time_we),
      .wr_addr (time_waddr),
      .wr_data (time_wdata),
      .rd_en   (rd_en),
      .rd_addr (rd_idx_ff[AW-1:0]),
      .rd_data (time_rd)
   );

endmodule

FILE: design/retransmit_tracker_cumulative_ack.sv
// ----------------------------------------------------------------------------
// retransmit_tracker_cumulative_ack
// Retransmission table with cumulative acknowledgement and timeout resend.
// ----------------------------------------------------------------------------
//  channel   dir  handshake        payload
//  req_bus   in   valid/ready      action, pack_id, now
//  rsp_bus   out  valid/ready      kind, out_id, last
//  csr_*     in   wr_en, no stall  wr_data = round_trip
//
// Send: result beat, then done beat. Confirm/tick over n entries reads one
// table entry per cycle while the response slot is free, through the single
// read port of each RAM, then a done beat. Reset clears the entry count, not
// the RAMs, which need no clearing. A stalled response freezes the scan.
// Timeout is registered from the round-trip register a csr write loads.
// ----------------------------------------------------------------------------
module retransmit_tracker_cumulative_ack import rtca_pkg::*; #(
   parameter int TABLE_DEPTH = DEPTH_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_wr_en,
   input  logic [RTT_W-1:0] csr_wr_data,
   rtca_req_if.sink         req_bus,
   rtca_rsp_if.source       rsp_bus
);

   logic [TIMEOUT_W-1:0] timeout;
   emit_type             emit;
   logic                 out_free;

   logic              valid_ff, valid_in;
   logic [KIND_W-1:0] kind_ff, kind_in;
   logic [ID_W-1:0]   out_id_ff, out_id_in;
   logic              last_ff, last_in;

   rtca_timeout u_timeout (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (csr_wr_en),
      .wr_data (csr_wr_data),
      .timeout (timeout)
   );

   rtca_engine #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_engine (
      .clock    (clock),
      .reset    (reset),
      .req_bus  (req_bus),
      .timeout  (timeout),
      .out_free (out_free),
      .emit     (emit)
   );

   assign out_free = !valid_ff || rsp_bus.ready;

   always_comb begin
      valid_in  = valid_ff && !rsp_bus.ready;
      kind_in   = kind_ff;
      out_id_in = out_id_ff;
      last_in   = last_ff;
      if (emit.valid) begin
         valid_in  = 1'b1;
         kind_in   = emit.kind;
         out_id_in = emit.id;
         last_in   = emit.last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff   <= kind_in;
      out_id_ff <= out_id_in;
      last_ff   <= last_in;
   end

   assign rsp_bus.valid  = valid_ff;
   assign rsp_bus.kind   = kind_ff;
   assign rsp_bus.out_id = out_id_ff;
   assign rsp_bus.last   = last_ff;

endmodule

FILE: tb/sv/retransmit_tracker_cumulative_ack_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// retransmit_tracker_cumulative_ack_tb
// Self-checking bench for the retransmit tracker. A directed set covers the
// field extremes, a full table, overflow, zero timeout, wrapped ages and the
// unused action code. Random phases follow, each under its own round-trip
// setting. The phases are mostly ordered sends, partial acks and advancing
// ticks, with some noise mixed in. Every response beat is checked against an
// in-bench table model.
// ----------------------------------------------------------------------------
module retransmit_tracker_cumulative_ack_tb;
   import rtca_pkg::*;

   localparam int TABLE_DEPTH = DEPTH_DEFAULT;
   localparam int STUCK_LIMIT = 2000;
   localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;

   typedef struct packed {
      logic [ACTION_W-1:0] action;
      logic [ID_W-1:0]     pack_id;
      logic [TIME_W-1:0]   now;
   } req_beat_type;

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic [ID_W-1:0]   id;
      logic              last;
   } rsp_beat_type;

   logic             clock = 1'b0;
   logic             reset;
   logic             csr_wr_en;
   logic [RTT_W-1:0] csr_wr_data;

   rtca_req_if req_bus ();
   rtca_rsp_if rsp_bus ();

   retransmit_tracker_cumulative_ack #(
      .TABLE_DEPTH(TABLE_DEPTH)
   ) u_top (
      .clock      (clock),
      .reset      (reset),
      .csr_wr_en  (csr_wr_en),
      .csr_wr_data(csr_wr_data),
      .req_bus    (req_bus),
      .rsp_bus    (rsp_bus)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // table model
   logic [ID_W-1:0]   tracked_id    [TABLE_DEPTH];
   logic [TIME_W-1:0] tracked_stamp [TABLE_DEPTH];
   int                tracked_count = 0;
   logic [RTT_W-1:0]  rtt_model = '0;

   req_beat_type req_backlog [$];
   rsp_beat_type awaited_beats [$];
   req_beat_type next_req;

   int  bad_beats = 0;
   int  req_gap = 0;
   int  rsp_stall = 0;
   bit  calm = 1'b0;

   logic [TIME_W-1:0] wall_clock = '0;
   logic [ID_W-1:0]   next_id;

   // floor(12 * rtt / 5), exact
   function automatic logic [TIME_W-1:0] expire_after(input logic [RTT_W-1:0] rtt);
      logic [39:0] scaled;
      scaled = {16'd0, rtt} * 40'd12;
      return TIME_W'(scaled / 40'd5);
   endfunction

   function automatic void await_beat(input logic [KIND_W-1:0] kind,
                                      input logic [ID_W-1:0] id, input logic last);
      rsp_beat_type b;
      b.kind = kind;
      b.id   = id;
      b.last = last;
      awaited_beats = {awaited_beats, b};
   endfunction

   task automatic track_action(input logic [ACTION_W-1:0] act,
                               input logic [ID_W-1:0] pid, input logic [TIME_W-1:0] t);
      int                keep;
      logic [TIME_W-1:0] limit;
      logic [TIME_W-1:0] age;
      case (act)
         ACT_SEND: begin
            if (tracked_count < TABLE_DEPTH) begin
               tracked_id[tracked_count]    = pid;
               tracked_stamp[tracked_count] = t;
               tracked_count++;
               await_beat(KIND_TRANSMIT, pid, 1'b0);
            end else begin
               await_beat(KIND_UNTRACKED, pid, 1'b0);
            end
         end
         ACT_CONFIRM: begin
            keep = 0;
            for (int i = 0; i < tracked_count; i++) begin
               if (pid >= tracked_id[i]) begin
                  await_beat(KIND_RELEASE, tracked_id[i], 1'b0);
               end else begin
                  tracked_id[keep]    = tracked_id[i];
                  tracked_stamp[keep] = tracked_stamp[i];
                  keep++;
               end
            end
            tracked_count = keep;
         end
         ACT_TICK: begin
            limit = expire_after(rtt_model);
            for (int i = 0; i < tracked_count; i++) begin
               age = t - tracked_stamp[i];
               if (age >= limit) begin
                  await_beat(KIND_RETRANSMIT, tracked_id[i], 1'b0);
                  tracked_stamp[i] = t;
               end
            end
         end
         default: ;
      endcase
      await_beat(KIND_DONE, '0, 1'b1);
   endtask

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
         req_gap = 0;
      end else begin
         if (req_bus.valid && req_bus.ready)
            track_action(req_bus.action, req_bus.pack_id, req_bus.now);
         if (!req_bus.valid || req_bus.ready) begin
            if (!calm && req_gap == 0 && $urandom_range(0, 7) == 0)
               req_gap = $urandom_range(1, 15);
            if (calm)
               req_gap = 0;
            if (req_gap > 0) begin
               req_gap--;
               req_bus.valid <= 1'b0;
            end else if (req_backlog.size() > 0) begin
               next_req = req_backlog.pop_front();
               req_bus.valid   <= 1'b1;
               req_bus.action  <= next_req.action;
               req_bus.pack_id <= next_req.pack_id;
               req_bus.now     <= next_req.now;
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   // response monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         rsp_stall = 0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (awaited_beats.size() == 0) begin
               bad_beats++;
               if (bad_beats <= 10)
                  $display("unexpected beat: kind=%0d id=%h last=%b",
                           rsp_bus.kind, rsp_bus.out_id, rsp_bus.last);
            end else begin
               automatic rsp_beat_type want = awaited_beats.pop_front();
               if (want.kind !== rsp_bus.kind || want.id !== rsp_bus.out_id ||
                   want.last !== rsp_bus.last) begin
                  bad_beats++;
                  if (bad_beats <= 10) begin
                     $write("beat mismatch: expected kind=%0d id=%h last=%b",
                            want.kind, want.id, want.last);
                     $display(", got kind=%0d id=%h last=%b",
                              rsp_bus.kind, rsp_bus.out_id, rsp_bus.last);
                  end
               end
            end
         end
         if (!calm && rsp_stall == 0 && $urandom_range(0, 7) == 0)
            rsp_stall = $urandom_range(1, 15);
         if (calm)
            rsp_stall = 0;
         if (rsp_stall > 0) begin
            rsp_stall--;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   // watchdog: cycles without any beat on either channel
   initial begin
      int stuck;
      stuck = 0;
      while (stuck < STUCK_LIMIT) begin
         @(posedge clock);
         if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
            stuck = 0;
         else
            stuck++;
      end
      $display("Regression FAIL");
      $finish;
   end

   task automatic queue_item(input logic [ACTION_W-1:0] act,
                             input logic [ID_W-1:0] pid, input logic [TIME_W-1:0] t);
      req_beat_type r;
      r.action  = act;
      r.pack_id = pid;
      r.now     = t;
      req_backlog = {req_backlog, r};
   endtask

   // block until every queued item went in and every response came back
   task automatic settle();
      do
         @(negedge clock);
      while (req_backlog.size() != 0 || req_bus.valid || awaited_beats.size() != 0);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_rtt(input logic [RTT_W-1:0] value);
      @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      rtt_model    = value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      // timeout settles through the round-trip and timeout registers after the write
      repeat (3) @(posedge clock);
      @(negedge clock);
   endtask

   // ordered sends, partial acks and advancing ticks, with some noise
   task automatic queue_mixed(input int count);
      int                pick;
      logic [ACTION_W-1:0] act;
      logic [ID_W-1:0]     pid;
      logic [TIME_W-1:0]   span;
      logic [TIME_W-1:0]   t;
      span = expire_after(rtt_model);
      for (int k = 0; k < count; k++) begin
         pick = $urandom_range(0, 99);
         wall_clock += $urandom_range(0, span / 3 + 2);
         if (pick < 42) begin
            act = ACT_SEND;
            pid = next_id;
            next_id += $urandom_range(1, 3);
         end else if (pick < 66) begin
            act = ACT_CONFIRM;
            pid = next_id - $urandom_range(1, 10);
         end else if (pick < 94) begin
            act = ACT_TICK;
            pid = $urandom;
            wall_clock += $urandom_range(0, span + span / 2 + 2);
         end else begin
            act = ACT_UNUSED;
            pid = $urandom;
         end
         if ($urandom_range(0, 9) == 0)
            pid = $urandom;
         t = ($urandom_range(0, 11) == 0) ? $urandom : wall_clock;
         queue_item(act, pid, t);
      end
   endtask

   initial begin
      reset           = 1'b1;
      csr_wr_en       = 1'b0;
      csr_wr_data     = '0;
      req_bus.valid   = 1'b0;
      req_bus.action  = ACT_SEND;
      req_bus.pack_id = '0;
      req_bus.now     = '0;
      rsp_bus.ready   = 1'b0;
      next_id         = $urandom;

      // reset timeout is zero: every tick resends everything
      queue_item(ACT_TICK, 32'd0, 32'd0);
      queue_item(ACT_SEND, 32'd0, 32'd0);
      queue_item(ACT_SEND, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      for (int k = 0; k < TABLE_DEPTH - 2; k++)
         queue_item(ACT_SEND, 32'd100 + k, 32'd3 * k);
      queue_item(ACT_SEND, 32'hDEAD_BEEF, 32'd50);        // table full
      queue_item(ACT_TICK, 32'd0, 32'd0);
      queue_item(ACT_CONFIRM, 32'd105, 32'd60);
      queue_item(ACT_CONFIRM, 32'd0, 32'd61);
      queue_item(ACT_UNUSED, 32'h5A5A_A5A5, 32'hA5A5_5A5A);
      queue_item(ACT_CONFIRM, 32'hFFFF_FFFF, 32'd62);
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      settle();

      // largest timeout: boundary on both sides, then an age across the wrap
      write_rtt(24'hFF_FFFF);
      queue_item(ACT_SEND, 32'd1, 32'h100);
      queue_item(ACT_TICK, 32'd0, 32'h100 + expire_after(24'hFF_FFFF) - 32'd1);
      queue_item(ACT_TICK, 32'd0, 32'h100 + expire_after(24'hFF_FFFF));
      queue_item(ACT_SEND, 32'd2, 32'hFFFF_FFF0);
      queue_item(ACT_TICK, 32'd0, 32'h10);
      settle();

      write_rtt(24'd0);
      queue_mixed(15);
      settle();

      write_rtt(24'd1);
      queue_mixed(15);
      settle();

      write_rtt(24'($urandom_range(2, 40)));
      queue_mixed(15);
      settle();

      write_rtt(24'($urandom));
      queue_mixed(15);
      settle();

      // last stretch runs with no idling on either side
      calm = 1'b1;
      write_rtt(24'hFF_FFFF);
      queue_mixed(15);
      settle();

      repeat (20) @(posedge clock);
      if (bad_beats == 0 && awaited_beats.size() == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule
